// ----- rtl/cau_pkg.sv -----
package cau_pkg;

	// number format and datapath widths
	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int MAG_W      = 64;
	// quotient bits kept by the divider, anything at or above 2**QB saturates anyway
	localparam int QB         = 33;
	localparam int XW         = MAG_W + FRAC_BITS;
	// result queue
	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_CONJ = 4'd4,
		OP_NEG  = 4'd5,
		OP_SWAP = 4'd6,
		OP_ABS  = 4'd7,
		OP_DIVR = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef struct packed {
		logic              sat;
		logic [DATA_W-1:0] val;
	} pk_t;

	// per-item info that rides alongside the divider
	typedef struct packed {
		logic              use_q;
		logic              neg_re;
		logic              neg_im;
		logic              ovf_re;
		logic              ovf_im;
		logic [DATA_W-1:0] res_re;
		logic [DATA_W-1:0] res_im;
		status_t           status;
	} side_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem_re;
		logic [MAG_W-1:0] rem_im;
		logic [QB-1:0]    xlo_re;
		logic [QB-1:0]    xlo_im;
		logic [MAG_W-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] re;
		logic [DATA_W-1:0] im;
		status_t           status;
	} res_t;

	localparam int RES_W = $bits(res_t);

	// sign and magnitude to a saturated two's complement word
	function automatic pk_t sat_pack(input logic neg, input logic [MAG_W-1:0] mag,
			input logic force_sat);
		pk_t              p;
		logic [MAG_W-1:0] lim;
		lim = neg ? (MAG_W'(1) << (DATA_W - 1))
			: ((MAG_W'(1) << (DATA_W - 1)) - MAG_W'(1));
		if (force_sat || (mag > lim)) begin
			p.sat = 1'b1;
			p.val = neg ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
		end else begin
			p.sat = 1'b0;
			p.val = neg ? ((~mag[DATA_W-1:0]) + DATA_W'(1)) : mag[DATA_W-1:0];
		end
		return p;
	endfunction

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem, input logic xb,
			input logic [MAG_W-1:0] den);
		logic [MAG_W:0] t;
		logic [MAG_W:0] d;
		logic [MAG_W:0] s;
		t = {rem, xb};
		d = {1'b0, den};
		s = t - d;
		if (t >= d) begin
			return {1'b1, s[MAG_W-1:0]};
		end
		return {1'b0, t[MAG_W-1:0]};
	endfunction

endpackage

// ----- rtl/cau_ram.sv -----
module cau_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cau_front.sv -----
module cau_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  logic [3:0]        op,
	input  logic [31:0]       a_re,
	input  logic [31:0]       a_im,
	input  logic [31:0]       b_re,
	input  logic [31:0]       b_im,
	output logic              out_v,
	output cau_pkg::side_t    out_side,
	output cau_pkg::div_in_t  out_div
);
	import cau_pkg::*;

	typedef enum logic [1:0] {
		K_FAST,
		K_DIV,
		K_UNK
	} kind_t;

	logic v_s1, v_s2, v_s3, v_s4;

	// s1: operands
	logic [3:0]               op_s1;
	logic signed [DATA_W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// s2: products
	logic [3:0]               op_s2;
	logic signed [DATA_W-1:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [MAG_W-1:0]  p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, p_bb_r_s2, p_bb_i_s2;

	// s3: sign and magnitude
	logic             neg_re_s3, neg_im_s3;
	logic [MAG_W-1:0] mag_re_s3, mag_im_s3, den_s3;
	kind_t            kind_s3;

	// s4
	side_t   side_s4;
	div_in_t div_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= op;
		ar_s1     <= a_re;
		ai_s1     <= a_im;
		br_s1     <= b_re;
		bi_s1     <= b_im;
		op_s2     <= op_s1;
		ar_s2     <= ar_s1;
		ai_s2     <= ai_s1;
		br_s2     <= br_s1;
		bi_s2     <= bi_s1;
		p_rr_s2   <= MAG_W'(ar_s1) * MAG_W'(br_s1);
		p_ii_s2   <= MAG_W'(ai_s1) * MAG_W'(bi_s1);
		p_ir_s2   <= MAG_W'(ai_s1) * MAG_W'(br_s1);
		p_ri_s2   <= MAG_W'(ar_s1) * MAG_W'(bi_s1);
		p_bb_r_s2 <= MAG_W'(br_s1) * MAG_W'(br_s1);
		p_bb_i_s2 <= MAG_W'(bi_s1) * MAG_W'(bi_s1);
	end

	// s2 -> s3
	logic signed [MAG_W:0]  vre, vim;
	logic signed [DATA_W:0] bx;
	logic [MAG_W-1:0]       mre, mim, den, bmag;
	logic                   nre, nim, is_mul, is_abs, is_divr;
	kind_t                  kind;

	always_comb begin
		vre     = '0;
		vim     = '0;
		den     = '0;
		is_mul  = 1'b0;
		is_abs  = 1'b0;
		is_divr = 1'b0;
		kind    = K_FAST;
		bx      = (DATA_W + 1)'(br_s2);
		bmag    = bx[DATA_W] ? MAG_W'(-bx) : MAG_W'(bx);
		case (op_t'(op_s2))
			OP_ADD: begin
				vre = (MAG_W + 1)'(ar_s2) + (MAG_W + 1)'(br_s2);
				vim = (MAG_W + 1)'(ai_s2) + (MAG_W + 1)'(bi_s2);
			end
			OP_SUB: begin
				vre = (MAG_W + 1)'(ar_s2) - (MAG_W + 1)'(br_s2);
				vim = (MAG_W + 1)'(ai_s2) - (MAG_W + 1)'(bi_s2);
			end
			OP_MUL: begin
				vre    = (MAG_W + 1)'(p_rr_s2) - (MAG_W + 1)'(p_ii_s2);
				vim    = (MAG_W + 1)'(p_ir_s2) + (MAG_W + 1)'(p_ri_s2);
				is_mul = 1'b1;
			end
			OP_DIV: begin
				vre  = (MAG_W + 1)'(p_rr_s2) + (MAG_W + 1)'(p_ii_s2);
				vim  = (MAG_W + 1)'(p_ir_s2) - (MAG_W + 1)'(p_ri_s2);
				den  = $unsigned(p_bb_r_s2) + $unsigned(p_bb_i_s2);
				kind = K_DIV;
			end
			OP_CONJ: begin
				vre = (MAG_W + 1)'(ar_s2);
				vim = -((MAG_W + 1)'(ai_s2));
			end
			OP_NEG: begin
				vre = -((MAG_W + 1)'(ar_s2));
				vim = -((MAG_W + 1)'(ai_s2));
			end
			OP_SWAP: begin
				vre = (MAG_W + 1)'(ai_s2);
				vim = (MAG_W + 1)'(ar_s2);
			end
			OP_ABS: begin
				vre    = (MAG_W + 1)'(ar_s2);
				vim    = (MAG_W + 1)'(ai_s2);
				is_abs = 1'b1;
			end
			OP_DIVR: begin
				vre     = (MAG_W + 1)'(ar_s2);
				vim     = (MAG_W + 1)'(ai_s2);
				den     = bmag;
				is_divr = 1'b1;
				kind    = K_DIV;
			end
			default: begin
				kind = K_UNK;
			end
		endcase
		mre = vre[MAG_W] ? MAG_W'(-vre) : MAG_W'(vre);
		mim = vim[MAG_W] ? MAG_W'(-vim) : MAG_W'(vim);
		nre = vre[MAG_W];
		nim = vim[MAG_W];
		if (is_mul) begin
			mre = mre >> FRAC_BITS;
			mim = mim >> FRAC_BITS;
		end
		if (is_abs) begin
			nre = 1'b0;
			nim = 1'b0;
		end
		if (is_divr) begin
			nre = ar_s2[DATA_W-1] ^ br_s2[DATA_W-1];
			nim = ai_s2[DATA_W-1] ^ br_s2[DATA_W-1];
		end
	end

	always_ff @(posedge clk) begin
		neg_re_s3 <= nre;
		neg_im_s3 <= nim;
		mag_re_s3 <= mre;
		mag_im_s3 <= mim;
		den_s3    <= den;
		kind_s3   <= kind;
	end

	// s3 -> s4
	logic                  dz;
	logic [MAG_W+QB-1:0]   wide_den;
	logic [XW-1:0]         x_re, x_im;
	pk_t                   pk_re, pk_im;
	side_t                 side;
	div_in_t               dv;

	always_comb begin
		dz            = (den_s3 == '0);
		wide_den      = (MAG_W + QB)'(den_s3) << (QB - FRAC_BITS);
		x_re          = XW'(mag_re_s3) << FRAC_BITS;
		x_im          = XW'(mag_im_s3) << FRAC_BITS;
		pk_re         = sat_pack(neg_re_s3, mag_re_s3, 1'b0);
		pk_im         = sat_pack(neg_im_s3, mag_im_s3, 1'b0);
		dv.rem_re     = MAG_W'(x_re >> QB);
		dv.rem_im     = MAG_W'(x_im >> QB);
		dv.xlo_re     = x_re[QB-1:0];
		dv.xlo_im     = x_im[QB-1:0];
		dv.den        = den_s3;
		side.neg_re   = neg_re_s3;
		side.neg_im   = neg_im_s3;
		// quotient of 2**QB or more is certain saturation
		side.ovf_re   = (MAG_W + QB)'(mag_re_s3) >= wide_den;
		side.ovf_im   = (MAG_W + QB)'(mag_im_s3) >= wide_den;
		side.use_q    = 1'b0;
		side.res_re   = '0;
		side.res_im   = '0;
		side.status   = ST_OK;
		case (kind_s3)
			K_FAST: begin
				side.res_re = pk_re.val;
				side.res_im = pk_im.val;
				side.status = (pk_re.sat || pk_im.sat) ? ST_SAT : ST_OK;
			end
			K_DIV: begin
				if (dz) begin
					side.status = ST_DZ;
				end else begin
					side.use_q = 1'b1;
				end
			end
			default: begin
				side.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		side_s4 <= side;
		div_s4  <= dv;
	end

	assign out_v    = v_s4;
	assign out_side = side_s4;
	assign out_div  = div_s4;

endmodule

// ----- rtl/cau_div.sv -----
module cau_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_v,
	input  cau_pkg::side_t           in_side,
	input  cau_pkg::div_in_t         in_div,
	output logic                     out_v,
	output cau_pkg::side_t           out_side,
	output logic [cau_pkg::QB-1:0]   q_re,
	output logic [cau_pkg::QB-1:0]   q_im
);
	import cau_pkg::*;

	logic             v_s    [QB];
	side_t            side_s [QB];
	logic [MAG_W-1:0] rre_s  [QB];
	logic [MAG_W-1:0] rim_s  [QB];
	logic [MAG_W-1:0] den_s  [QB];
	logic [QB-1:0]    xre_s  [QB];
	logic [QB-1:0]    xim_s  [QB];
	logic [QB-1:0]    qre_s  [QB];
	logic [QB-1:0]    qim_s  [QB];

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic             pv;
		side_t            ps;
		logic [MAG_W-1:0] prr, pri, pd;
		logic [QB-1:0]    pxr, pxi, pqr, pqi;
		logic [MAG_W:0]   sr, si;

		if (k == 0) begin : g_first
			assign pv  = in_v;
			assign ps  = in_side;
			assign prr = in_div.rem_re;
			assign pri = in_div.rem_im;
			assign pd  = in_div.den;
			assign pxr = in_div.xlo_re;
			assign pxi = in_div.xlo_im;
			assign pqr = '0;
			assign pqi = '0;
		end else begin : g_next
			assign pv  = v_s[k-1];
			assign ps  = side_s[k-1];
			assign prr = rre_s[k-1];
			assign pri = rim_s[k-1];
			assign pd  = den_s[k-1];
			assign pxr = xre_s[k-1];
			assign pxi = xim_s[k-1];
			assign pqr = qre_s[k-1];
			assign pqi = qim_s[k-1];
		end

		assign sr = div_step(prr, pxr[QB-1-k], pd);
		assign si = div_step(pri, pxi[QB-1-k], pd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= ps;
			rre_s[k]  <= sr[MAG_W-1:0];
			rim_s[k]  <= si[MAG_W-1:0];
			den_s[k]  <= pd;
			xre_s[k]  <= pxr;
			xim_s[k]  <= pxi;
			qre_s[k]  <= {pqr[QB-2:0], sr[MAG_W]};
			qim_s[k]  <= {pqi[QB-2:0], si[MAG_W]};
		end
	end

	assign out_v    = v_s[QB-1];
	assign out_side = side_s[QB-1];
	assign q_re     = qre_s[QB-1];
	assign q_im     = qim_s[QB-1];

endmodule

// ----- rtl/cau_outq.sv -----
module cau_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_acc,
	input  logic           wr_v,
	input  cau_pkg::res_t  wr_data,
	output logic           full,
	output logic           out_v,
	output cau_pkg::res_t  out_data,
	input  logic           out_stall
);
	import cau_pkg::*;

	logic [CNT_W-1:0]   cnt_q, fcnt_q;
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic               rd_v_q, out_v_q, skid_v_q;
	res_t               out_q, skid_q, arr, out_d, skid_d;
	logic               out_v_d, skid_v_d;
	logic [RES_W-1:0]   rdata;
	logic               take, issue;
	logic [1:0]         occ;

	cau_ram #(
		.W     (RES_W),
		.DEPTH (FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_v),
		.waddr (wptr_q),
		.wdata (wr_data),
		.re    (issue),
		.raddr (rptr_q),
		.rdata (rdata)
	);

	assign arr   = res_t'(rdata);
	assign take  = out_v_q && !out_stall;
	// beats held in the output pair plus one read in flight, after this cycle's take
	assign occ   = 2'(out_v_q) + 2'(skid_v_q) + 2'(rd_v_q) - 2'(take);
	assign issue = (fcnt_q != '0) && (occ < 2'd2);
	// credit: every accepted item has a queue slot reserved
	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));

	always_comb begin
		out_v_d  = out_v_q;
		skid_v_d = skid_v_q;
		out_d    = out_q;
		skid_d   = skid_q;
		if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_d  = 1'b1;
				out_d    = skid_q;
				skid_v_d = rd_v_q;
				skid_d   = arr;
			end else if (rd_v_q) begin
				out_v_d  = 1'b1;
				out_d    = arr;
				skid_v_d = 1'b0;
			end else begin
				out_v_d  = 1'b0;
				skid_v_d = 1'b0;
			end
		end else if (!skid_v_q && rd_v_q) begin
			skid_v_d = 1'b1;
			skid_d   = arr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			fcnt_q   <= '0;
			wptr_q   <= '0;
			rptr_q   <= '0;
			rd_v_q   <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			cnt_q    <= cnt_q + CNT_W'(in_acc) - CNT_W'(take);
			fcnt_q   <= fcnt_q + CNT_W'(wr_v) - CNT_W'(issue);
			wptr_q   <= wptr_q + FIFO_AW'(wr_v);
			rptr_q   <= rptr_q + FIFO_AW'(issue);
			rd_v_q   <= issue;
			out_v_q  <= out_v_d;
			skid_v_q <= skid_v_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q  <= out_d;
		skid_q <= skid_d;
	end

	assign out_v    = out_v_q;
	assign out_data = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(out_v_q) + 32'(skid_v_q) + 32'(rd_v_q)) <= 32'd2)
		else $error("output pair overrun");

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat while output is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_v |-> (fcnt_q < CNT_W'(FIFO_DEPTH)))
		else $error("queue write while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= cnt_q)
		else $error("queue holds more than outstanding credit");

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex ALU on signed Q16.16 operands: add, sub, mul, complex divide, conj, neg, swap,
// component-wise abs and divide by the real scalar b_re. Every item gives exactly one result
// beat with a status (ok, divide by zero, saturated). The pipeline takes one item per clock
// while in_stall is low. Each item passes through the operand register, 32x32 multipliers,
// sign/magnitude and pack, the restoring divider (one quotient bit per stage, both parts side
// by side) that every item passes through, one pack stage, and the 64-entry result queue
// (write, read, output register). The pipeline itself never stalls; a back-pressured output
// fills the queue, and in_stall rises once 64 items are outstanding. Results are truncated
// toward zero and saturate on overflow.
module complex_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  op,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] res_re,
	output logic [31:0] res_im,
	output logic [1:0]  status
);
	import cau_pkg::*;

	logic          in_acc;
	logic          fr_v, dv_v;
	side_t         fr_side, dv_side;
	div_in_t       fr_div;
	logic [QB-1:0] q_re, q_im;
	logic          full;
	res_t          out_data;

	// final pack stage, after front (4) and divider (QB) stages
	logic          v_s38;
	res_t          res_s38;
	pk_t           pk_re, pk_im;
	res_t          res;

	// an input beat is taken whenever the queue still has credit
	assign in_stall = full;
	assign in_acc   = in_valid && !in_stall;

	// operand regs, products, sign/magnitude, overflow precheck and fast-op pack
	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (in_acc),
		.op       (op),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.out_v    (fr_v),
		.out_side (fr_side),
		.out_div  (fr_div)
	);

	// quotient pipeline; non-divide items ride along with their finished result
	cau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (fr_v),
		.in_side  (fr_side),
		.in_div   (fr_div),
		.out_v    (dv_v),
		.out_side (dv_side),
		.q_re     (q_re),
		.q_im     (q_im)
	);

	// divide results get signed and saturated here, others pass as they are
	always_comb begin
		pk_re = sat_pack(dv_side.neg_re, MAG_W'(q_re), dv_side.ovf_re);
		pk_im = sat_pack(dv_side.neg_im, MAG_W'(q_im), dv_side.ovf_im);
		if (dv_side.use_q) begin
			res.re     = pk_re.val;
			res.im     = pk_im.val;
			res.status = (pk_re.sat || pk_im.sat) ? ST_SAT : ST_OK;
		end else begin
			res.re     = dv_side.res_re;
			res.im     = dv_side.res_im;
			res.status = dv_side.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s38 <= 1'b0;
		end else begin
			v_s38 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		res_s38 <= res;
	end

	// result queue with output register and skid, parts the pipeline from the consumer
	cau_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.wr_v      (v_s38),
		.wr_data   (res_s38),
		.full      (full),
		.out_v     (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

	assign res_re = out_data.re;
	assign res_im = out_data.im;
	assign status = out_data.status;

endmodule

// ----- bench/complex_arithmetic_unit_tb.sv -----
module complex_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cau_pkg::*;

	localparam int RAND_ITEMS = 800;
	localparam int MAX_SHOWN  = 10;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] a_re;
		logic [31:0] a_im;
		logic [31:0] b_re;
		logic [31:0] b_im;
	} operands_t;

	// a directed row; exp_known marks rows whose answer is typed in
	typedef struct {
		operands_t   opnd;
		bit          exp_known;
		logic [31:0] exp_re;
		logic [31:0] exp_im;
		status_t     exp_st;
	} vec_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  op;
	logic [31:0] a_re;
	logic [31:0] a_im;
	logic [31:0] b_re;
	logic [31:0] b_im;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] res_re;
	logic [31:0] res_im;
	logic [1:0]  status;

	res_t        pending_res[$];
	int          mismatches;

	complex_arithmetic_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_re    (res_re),
		.res_im    (res_im),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// saturate a sign and magnitude pair into a 32-bit word
	function automatic logic [31:0] clamp_word(input bit neg, input logic [63:0] mag,
			inout bit sat);
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return mag[31:0];
		end
		if (mag > 64'h8000_0000) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return 32'(-mag);
	endfunction

	// sum of two signed products as sign and magnitude (each within +-2^62)
	function automatic logic [63:0] sum_mag(input logic signed [63:0] p,
			input logic signed [63:0] q, output bit neg);
		logic signed [64:0] s;
		s = 65'(p) + 65'(q);
		neg = s < 0;
		return neg ? 64'(-s) : 64'(s);
	endfunction

	function automatic logic [63:0] mag_of(input logic signed [63:0] v, output bit neg);
		neg = v < 0;
		return neg ? 64'(-v) : 64'(v);
	endfunction

	// floor(num * 2^16 / den), capped just above the 32-bit range
	function automatic logic [63:0] fixed_quot(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] cap;
		cap = 64'd1 << 33;
		q = num / den;
		r = num % den;
		if (q > cap) q = cap;
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
			if (q > cap) q = cap;
		end
		return q;
	endfunction

	function automatic res_t complex_result(input operands_t x);
		logic signed [63:0] ar, ai, br, bi;
		logic [63:0]        mre, mim, den;
		bit                 nre, nim, nb, sat, known;
		res_t               r;
		ar = 64'(signed'(x.a_re));
		ai = 64'(signed'(x.a_im));
		br = 64'(signed'(x.b_re));
		bi = 64'(signed'(x.b_im));
		mre = '0;
		mim = '0;
		nre = 0;
		nim = 0;
		sat = 0;
		known = 1;
		r.re = '0;
		r.im = '0;
		r.status = ST_OK;
		case (x.op)
			OP_ADD: begin
				mre = mag_of(ar + br, nre);
				mim = mag_of(ai + bi, nim);
			end
			OP_SUB: begin
				mre = mag_of(ar - br, nre);
				mim = mag_of(ai - bi, nim);
			end
			OP_MUL: begin
				mre = sum_mag(ar * br, -(ai * bi), nre) >> FRAC_BITS;
				mim = sum_mag(ai * br, ar * bi, nim) >> FRAC_BITS;
			end
			OP_DIV: begin
				den = 64'(br * br) + 64'(bi * bi);
				if (den == 0) r.status = ST_DZ;
				else begin
					mre = fixed_quot(sum_mag(ar * br, ai * bi, nre), den);
					mim = fixed_quot(sum_mag(ai * br, -(ar * bi), nim), den);
				end
			end
			OP_CONJ: begin
				mre = mag_of(ar, nre);
				mim = mag_of(-ai, nim);
			end
			OP_NEG: begin
				mre = mag_of(-ar, nre);
				mim = mag_of(-ai, nim);
			end
			OP_SWAP: begin
				mre = mag_of(ai, nre);
				mim = mag_of(ar, nim);
			end
			OP_ABS: begin
				mre = mag_of(ar, nre);
				mim = mag_of(ai, nim);
				nre = 0;
				nim = 0;
			end
			OP_DIVR: begin
				den = mag_of(br, nb);
				if (den == 0) r.status = ST_DZ;
				else begin
					mre = fixed_quot(mag_of(ar, nre), den);
					mim = fixed_quot(mag_of(ai, nim), den);
					nre = nre ^ nb;
					nim = nim ^ nb;
				end
			end
			default: known = 0;
		endcase
		if (known && r.status == ST_OK) begin
			r.re = clamp_word(nre, mre, sat);
			r.im = clamp_word(nim, mim, sat);
			if (sat) r.status = ST_SAT;
		end
		return r;
	endfunction

	// operand value that leans toward the edges of the range
	function automatic logic [31:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'(signed'($urandom_range(0, 8)) - 4) << 16;
			4, 5: return 32'(signed'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
			6: return 32'(signed'($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	// one beat onto the input channel, with a random gap pattern in bursts
	int burst_left;
	task automatic send_beat(input operands_t x);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op       <= x.op;
		a_re     <= x.a_re;
		a_im     <= x.a_im;
		b_re     <= x.b_re;
		b_im     <= x.b_im;
		// beat taken at the first edge with stall low
		do @(posedge clk); while (in_stall);
		pending_res.push_back(complex_result(x));
	endtask

	// receiver stall pattern: random stretches of free run, light stall, heavy stall or constant stall
	initial begin
		int mode;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 80)) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= 1'b1;
				endcase
			end
		end
	end

	// result checker
	initial begin
		res_t want;
		mismatches = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_res.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected result beat re=%h im=%h st=%0d",
							res_re, res_im, status);
				end else begin
					want = pending_res.pop_front();
					if (res_re !== want.re || res_im !== want.im || status !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
								want.re, want.im, want.status, res_re, res_im, status);
					end
				end
			end
		end
	end

	initial begin
		vec_row_t  vecs[$];
		vec_row_t  row;
		operands_t x;
		int        wait_cycles;
		burst_left = 0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		op       = '0;
		a_re     = '0;
		a_im     = '0;
		b_re     = '0;
		b_im     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: extremes, every op, divide by zero, saturation, unknown op
		vecs = '{
			'{'{OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF},
				1, 32'h7FFF_FFFF, 32'h8000_0000, ST_SAT},
			'{'{OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000},
				1, 32'h0004_0000, 32'h0001_0000, ST_OK},
			'{'{OP_SUB, 32'h8000_0000, 32'h0, 32'h1, 32'h0},
				1, 32'h8000_0000, 32'h0, ST_SAT},
			'{'{OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000},
				0, '0, '0, ST_OK},
			'{'{OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
				0, '0, '0, ST_OK},
			'{'{OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0},
				1, 32'h0, 32'h0, ST_DZ},
			'{'{OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000},
				0, '0, '0, ST_OK},
			'{'{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1},
				0, '0, '0, ST_OK},
			'{'{OP_CONJ, 32'h1234_5678, 32'h8000_0000, 32'hDEAD_BEEF, 32'h1},
				1, 32'h1234_5678, 32'h7FFF_FFFF, ST_SAT},
			'{'{OP_NEG, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
				1, 32'h8000_0001, 32'h0000_0001, ST_OK},
			'{'{OP_NEG, 32'h8000_0000, 32'h0, 32'h0, 32'h0},
				1, 32'h7FFF_FFFF, 32'h0, ST_SAT},
			'{'{OP_SWAP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
				1, 32'h7FFF_FFFF, 32'h8000_0000, ST_OK},
			'{'{OP_ABS, 32'hFFFF_0000, 32'h8000_0000, 32'h0, 32'h0},
				1, 32'h0001_0000, 32'h7FFF_FFFF, ST_SAT},
			'{'{OP_DIVR, 32'h0005_0000, 32'h0005_0000, 32'h0, 32'h7FFF_FFFF},
				1, 32'h0, 32'h0, ST_DZ},
			'{'{OP_DIVR, 32'h0006_0000, 32'hFFFA_0000, 32'hFFFE_0000, 32'h0},
				0, '0, '0, ST_OK},
			'{'{OP_DIVR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0},
				0, '0, '0, ST_OK},
			'{'{4'd9, 32'h1, 32'h1, 32'h1, 32'h1}, 1, 32'h0, 32'h0, ST_OK},
			'{'{4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
				1, 32'h0, 32'h0, ST_OK}
		};
		foreach (vecs[i]) begin
			row = vecs[i];
			// typed-in answers must agree with the predictor too
			if (row.exp_known) begin
				x = row.opnd;
				if (complex_result(x) != res_t'{row.exp_re, row.exp_im, row.exp_st}) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("table row %0d disagrees with prediction", i);
				end
			end
			send_beat(row.opnd);
		end

		// random part: mostly known ops, a few unknown codes
		repeat (RAND_ITEMS) begin
			x.op   = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			x.a_re = pick_part();
			x.a_im = pick_part();
			x.b_re = pick_part();
			x.b_im = pick_part();
			send_beat(x);
		end
		in_valid <= 1'b0;

		// drain, then a quiet stretch for late or stray beats
		wait_cycles = 0;
		while (pending_res.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/cau_pkg.sv
rtl/cau_ram.sv
rtl/cau_front.sv
rtl/cau_div.sv
rtl/cau_outq.sv
rtl/complex_arithmetic_unit.sv
bench/complex_arithmetic_unit_tb.sv
